// ===== rtl/nfsa_pkg.sv =====
// shared types and constants of the next-fit slot allocator
`default_nettype none

package nfsa_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;
  localparam int unsigned SLOT_W = 9;
  localparam int unsigned WIDX_W = 4;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_REL  = 3'b100
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/nfsa_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module nfsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/next_fit_slot_allocator.sv =====
// next-fit slot allocator: bitmap in ram, word-wise circular search
//
// Requests arrive on the in channel (valid/ready): req_type_i selects allocate
// or release, slot_to_release_i names the slot for a release. Every request
// gives one word on the out channel: the slot, a status code and the number
// of slots in use afterwards. The cfg channel writes active_slots, the wrap
// point of the search; the user must write it only while no request is in
// flight, and the block itself does not enforce this. The in-use bitmap
// lives in a ram of 32-bit words, one word read per cycle. A release goes
// through S_REL and back to idle before the next acceptance. An allocate
// reads the start word, every other active word, and the start word again
// for the bits below the search start: up to ceil(n/32) + 1 word reads.
// The last word read passes the ram's read register before the result is
// registered in the output register. A new request is taken while a result
// still waits in the output register; if the receiver stalls, the next
// result waits in the scan or release state until the register frees, and
// the bitmap is written back only then. Reset frees every slot at once
// through per-word valid flags, clears the count and search start, and sets active_slots to 256.
`default_nettype none

module next_fit_slot_allocator
  import nfsa_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [8:0] cfg_active_slots_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] slot_to_release_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      slot_index_o,
  output logic [1:0]      status_o,
  output logic [8:0]      used_count_o
);

  localparam int unsigned MAXN   = (CAPACITY < 511) ? CAPACITY : 511;
  localparam int unsigned NWORDS = (MAXN + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned DEPTH  = 2 ** AW;

  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   cfg_q;
  logic [7:0]          rel_q, rel_d;
  logic [SLOT_W-1:0]   n_q, n_d;
  logic [SLOT_W-1:0]   nm1_q, nm1_d;
  logic [SLOT_W-1:0]   p0_q, p0_d;
  logic [WIDX_W-1:0]   cur_w_q, cur_w_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SLOT_W-1:0]   ss_q, ss_d;
  logic [SLOT_W-1:0]   used_q, used_d;
  logic [DEPTH-1:0]    wvalid_q, wvalid_d;
  logic                rvalid_q, rvalid_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          slot_q, slot_d;
  status_e             status_q, status_d;
  logic [SLOT_W-1:0]   count_q, count_d;

  logic [SLOT_W-1:0]   n_c;
  logic [SLOT_W-1:0]   p0_c;
  logic [SLOT_W-1:0]   rel_ext;
  logic                in_acc;
  logic                out_free;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic [WORD_W-1:0]   rword;
  logic [WORD_W-1:0]   range_mask, lo_mask, cand;
  logic                first_v, last_v, found;
  logic [BIT_W-1:0]    bitpos;
  logic [SLOT_W-1:0]   slot_c, next_ss;
  logic [WIDX_W-1:0]   next_w;

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign in_acc       = in_valid_i & in_ready_o;
  assign out_free     = ~out_valid_q | out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign slot_index_o = slot_q;
  assign status_o     = status_q;
  assign used_count_o = count_q;

  assign n_c = (cfg_q == '0) ? SLOT_W'(1)
             : ((cfg_q > SLOT_W'(MAXN)) ? SLOT_W'(MAXN) : cfg_q);
  assign p0_c    = (ss_q < n_c) ? ss_q : '0;
  assign rel_ext = {1'b0, slot_to_release_i};

  assign rword      = rvalid_q ? ram_rdata : '0;
  assign range_mask = (cur_w_q == nm1_q[SLOT_W-1:BIT_W])
                    ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - nm1_q[BIT_W-1:0]))
                    : {WORD_W{1'b1}};
  assign lo_mask = {WORD_W{1'b1}} << p0_q[BIT_W-1:0];
  assign first_v = (cnt_q == '0);
  assign last_v  = (cnt_q == (CNT_W'(nm1_q[SLOT_W-1:BIT_W]) + CNT_W'(1)));
  assign cand    = ~rword & range_mask & (first_v ? lo_mask : {WORD_W{1'b1}})
                 & (last_v ? ~lo_mask : {WORD_W{1'b1}});
  assign found   = |cand;

  always_comb begin
    bitpos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        bitpos = BIT_W'(i);
      end
    end
  end

  assign slot_c  = {cur_w_q, bitpos};
  assign next_ss = ((slot_c + SLOT_W'(1)) >= n_q) ? '0 : (slot_c + SLOT_W'(1));
  assign next_w  = (cur_w_q == nm1_q[SLOT_W-1:BIT_W]) ? '0 : (cur_w_q + WIDX_W'(1));

  always_comb begin
    state_d     = state_q;
    rel_d       = rel_q;
    n_d         = n_q;
    nm1_d       = nm1_q;
    p0_d        = p0_q;
    cur_w_d     = cur_w_q;
    cnt_d       = cnt_q;
    ss_d        = ss_q;
    used_d      = used_q;
    wvalid_d    = wvalid_q;
    rvalid_d    = rvalid_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    slot_d      = slot_q;
    status_d    = status_q;
    count_d     = count_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = cur_w_q[AW-1:0];
    ram_wdata   = rword;
    ram_raddr   = cur_w_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rel_d  = slot_to_release_i;
          n_d    = n_c;
          nm1_d  = n_c - SLOT_W'(1);
          p0_d   = p0_c;
          cnt_d  = '0;
          ram_re = 1'b1;
          if (req_type_i == REQ_ALLOC) begin
            cur_w_d   = p0_c[SLOT_W-1:BIT_W];
            ram_raddr = p0_c[BIT_W +: AW];
            state_d   = S_SCAN;
          end else begin
            cur_w_d   = rel_ext[SLOT_W-1:BIT_W];
            ram_raddr = rel_ext[BIT_W +: AW];
            state_d   = S_REL;
          end
          rvalid_d = wvalid_q[ram_raddr];
        end
      end
      S_SCAN: begin
        if (found || last_v) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
            if (found) begin
              ram_we                     = 1'b1;
              ram_wdata                  = rword | (WORD_W'(1) << bitpos);
              wvalid_d[cur_w_q[AW-1:0]]  = 1'b1;
              used_d                     = used_q + SLOT_W'(1);
              ss_d                       = next_ss;
              slot_d                     = slot_c[7:0];
              status_d                   = ST_OK;
              count_d                    = used_q + SLOT_W'(1);
            end else begin
              slot_d   = '0;
              status_d = ST_FULL;
              count_d  = used_q;
            end
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = next_w[AW-1:0];
          cur_w_d   = next_w;
          cnt_d     = cnt_q + CNT_W'(1);
          rvalid_d  = wvalid_q[next_w[AW-1:0]];
        end
      end
      S_REL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          slot_d      = rel_q;
          count_d     = used_q;
          if ({1'b0, rel_q} >= n_q) begin
            status_d = ST_RANGE;
          end else if (!rword[rel_q[BIT_W-1:0]]) begin
            status_d = ST_NOT_USED;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = rword & ~(WORD_W'(1) << rel_q[BIT_W-1:0]);
            status_d  = ST_OK;
            if (used_q != '0) begin
              used_d  = used_q - SLOT_W'(1);
              count_d = used_q - SLOT_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= SLOT_W'(256);
      ss_q        <= '0;
      used_q      <= '0;
      wvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ss_q        <= ss_d;
      used_q      <= used_d;
      wvalid_q    <= wvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_active_slots_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q    <= rel_d;
    n_q      <= n_d;
    nm1_q    <= nm1_d;
    p0_q     <= p0_d;
    cur_w_q  <= cur_w_d;
    cnt_q    <= cnt_d;
    rvalid_q <= rvalid_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    count_q  <= count_d;
  end

  nfsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/nfsa_chk.sv =====
// port-level checker for the next-fit slot allocator, bound to the top level
`default_nettype none

module nfsa_chk
  import nfsa_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] slot_index_o,
  input wire logic [1:0] status_o,
  input wire logic [8:0] used_count_o
);

  logic       seen_q;
  logic [8:0] last_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_count_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q       <= 1'b1;
      last_count_q <= used_count_o;
    end
  end

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_index_o)
      && $stable(status_o) && $stable(used_count_o))
    else $error("out word changed while stalled");

  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> slot_index_o == '0)
    else $error("full result with nonzero slot");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q && (status_o != ST_OK) |-> used_count_o == last_count_q)
    else $error("failed request changed the count");

  a_ok_steps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_q && (status_o == ST_OK)
      |-> (used_count_o == last_count_q + 9'd1) || (used_count_o == last_count_q - 9'd1))
    else $error("served request moved the count by other than one");

endmodule

bind next_fit_slot_allocator nfsa_chk u_nfsa_chk (.*);

`default_nettype wire
